// ===== rtl/core/windowed_min_path_dp_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the windowed minimum-path cost block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MIN_PATH_DP_TOP_ASSERT_SVH
`define WINDOWED_MIN_PATH_DP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define WMPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WMPD_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define WMPD_ASSERT(label, clk, rst, prop, msg)
`define WMPD_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ===== rtl/core/wmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Windowed minimum-path cost package
// Widths, reset values, register indexes, states and control structs.
// ----------------------------------------------------------------------------
package wmpd_pkg;

  localparam int MAX_COLS  = 64;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int USED_W    = COL_W + 1;
  localparam int RAD_W     = 6;
  localparam int ENTRY_W   = 16;
  localparam int COST_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [COST_W-1:0] COST_TOP    = '1;
  localparam logic [USED_W-1:0] USED_RESET  = USED_W'(64);
  localparam logic [RAD_W-1:0]  RAD_RESET   = RAD_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USED_COLUMNS  = 1'b0,
    CFG_WINDOW_RADIUS = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic write;
    logic emit_rd;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic first_row;
    logic scan_done;
    logic row_end;
    logic end_flag;
    logic emit_last;
  } sts_t;

endpackage

// ===== rtl/core/wmpd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wmpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/wmpd_datapath.sv =====
// ----------------------------------------------------------------------------
// Windowed minimum-path cost datapath
// Cost row banks, predecessor store, window scan and result fields.
// ----------------------------------------------------------------------------
module wmpd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wmpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wmpd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [wmpd_pkg::ENTRY_W-1:0]        entry,
  input  logic                                end_of_matrix,
  input  wmpd_pkg::cmd_t                      cmd,
  output wmpd_pkg::sts_t                      sts,
  output logic [wmpd_pkg::COL_W-1:0]          column,
  output logic [wmpd_pkg::COL_W-1:0]          predecessor,
  output logic                                has_predecessor,
  output logic                                last
);

  logic [wmpd_pkg::USED_W-1:0]  used_columns;
  logic [wmpd_pkg::RAD_W-1:0]   window_radius;
  logic [wmpd_pkg::COL_W-1:0]   column_counter;
  logic                         first_row;
  logic                         bank;
  logic                         had;
  logic [wmpd_pkg::ENTRY_W-1:0] entry_q;
  logic                         end_q;
  logic [wmpd_pkg::COL_W-1:0]   col_q;
  logic [wmpd_pkg::COL_W-1:0]   rd_ptr;
  logic [wmpd_pkg::COL_W-1:0]   hi_q;
  logic                         first_pend;
  logic                         rd_valid;
  logic                         rd_first;
  logic [wmpd_pkg::COL_W-1:0]   rd_idx;
  logic [wmpd_pkg::COST_W-1:0]  best_cost;
  logic [wmpd_pkg::COL_W-1:0]   best_idx;
  logic [wmpd_pkg::COL_W-1:0]   emit_col;

  logic [wmpd_pkg::USED_W-1:0]  used_dec;
  logic [wmpd_pkg::COL_W-1:0]   used_m1;
  logic [wmpd_pkg::COL_W-1:0]   col_in;
  logic [wmpd_pkg::COL_W-1:0]   lo_in;
  logic [wmpd_pkg::COL_W:0]     hi_sum;
  logic [wmpd_pkg::COL_W-1:0]   hi_in;
  logic [wmpd_pkg::COST_W:0]    sum_wide;
  logic [wmpd_pkg::COST_W-1:0]  wr_cost;
  logic [wmpd_pkg::COST_W-1:0]  rd_cost0;
  logic [wmpd_pkg::COST_W-1:0]  rd_cost1;
  logic [wmpd_pkg::COST_W-1:0]  rd_cost;
  logic [wmpd_pkg::COL_W-1:0]   pred_rd;
  logic                         row_end;

  assign used_dec = used_columns - 1'b1;

  always_comb begin
    if (used_columns == '0) begin
      used_m1 = '0;
    end else if (used_columns > wmpd_pkg::USED_W'(wmpd_pkg::MAX_COLS)) begin
      used_m1 = wmpd_pkg::COL_W'(wmpd_pkg::MAX_COLS - 1);
    end else begin
      used_m1 = used_dec[wmpd_pkg::COL_W-1:0];
    end
  end

  assign col_in = (column_counter > used_m1) ? used_m1 : column_counter;
  assign lo_in  = (col_in > window_radius) ? (col_in - window_radius) : '0;
  assign hi_sum = {1'b0, col_in} + {1'b0, window_radius};
  assign hi_in  = (hi_sum > {1'b0, used_m1}) ? used_m1 : hi_sum[wmpd_pkg::COL_W-1:0];

  assign rd_cost  = bank ? rd_cost1 : rd_cost0;
  assign sum_wide = {1'b0, best_cost} + {{(wmpd_pkg::COST_W - wmpd_pkg::ENTRY_W + 1){1'b0}}, entry_q};

  always_comb begin
    if (first_row) begin
      wr_cost = {{(wmpd_pkg::COST_W - wmpd_pkg::ENTRY_W){1'b0}}, entry_q};
    end else if (sum_wide[wmpd_pkg::COST_W]) begin
      wr_cost = wmpd_pkg::COST_TOP;
    end else begin
      wr_cost = sum_wide[wmpd_pkg::COST_W-1:0];
    end
  end

  assign row_end = (col_q == used_m1);

  wmpd_ram #(
    .WIDTH (wmpd_pkg::COST_W),
    .DEPTH (wmpd_pkg::MAX_COLS)
  ) u_cost0 (
    .clk     (clk),
    .wr_en   (cmd.write && bank),
    .wr_addr (col_q),
    .wr_data (wr_cost),
    .rd_en   (cmd.scan && !bank),
    .rd_addr (rd_ptr),
    .rd_data (rd_cost0)
  );

  wmpd_ram #(
    .WIDTH (wmpd_pkg::COST_W),
    .DEPTH (wmpd_pkg::MAX_COLS)
  ) u_cost1 (
    .clk     (clk),
    .wr_en   (cmd.write && !bank),
    .wr_addr (col_q),
    .wr_data (wr_cost),
    .rd_en   (cmd.scan && bank),
    .rd_addr (rd_ptr),
    .rd_data (rd_cost1)
  );

  wmpd_ram #(
    .WIDTH (wmpd_pkg::COL_W),
    .DEPTH (wmpd_pkg::MAX_COLS)
  ) u_pred (
    .clk     (clk),
    .wr_en   (cmd.write && !first_row),
    .wr_addr (col_q),
    .wr_data (best_idx),
    .rd_en   (cmd.emit_rd),
    .rd_addr (emit_col),
    .rd_data (pred_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used_columns   <= wmpd_pkg::USED_RESET;
      window_radius  <= wmpd_pkg::RAD_RESET;
      column_counter <= '0;
      first_row      <= 1'b1;
      bank           <= 1'b0;
      had            <= 1'b0;
      first_pend     <= 1'b0;
      rd_valid       <= 1'b0;
      emit_col       <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == wmpd_pkg::CFG_USED_COLUMNS) begin
          used_columns <= cfg_data[wmpd_pkg::USED_W-1:0];
        end else begin
          window_radius <= cfg_data[wmpd_pkg::RAD_W-1:0];
        end
      end
      rd_valid <= cmd.scan;
      if (cmd.load) begin
        first_pend <= 1'b1;
      end else if (cmd.scan) begin
        first_pend <= 1'b0;
      end
      if (cmd.write) begin
        if (row_end) begin
          bank           <= !bank;
          column_counter <= '0;
          had            <= !first_row;
          first_row      <= end_q;
          emit_col       <= '0;
        end else begin
          column_counter <= col_q + 1'b1;
        end
      end
      if (cmd.emit_next) begin
        emit_col <= emit_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry_q <= entry;
      end_q   <= end_of_matrix;
      col_q   <= col_in;
      rd_ptr  <= lo_in;
      hi_q    <= hi_in;
    end else if (cmd.scan) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
    if (cmd.scan) begin
      rd_first <= first_pend;
      rd_idx   <= rd_ptr;
    end
    if (rd_valid && (rd_first || (rd_cost < best_cost))) begin
      best_cost <= rd_cost;
      best_idx  <= rd_idx;
    end
  end

  assign sts.first_row = first_row;
  assign sts.scan_done = (rd_ptr == hi_q);
  assign sts.row_end   = row_end;
  assign sts.end_flag  = end_q;
  assign sts.emit_last = (emit_col == used_m1);

  assign column          = emit_col;
  assign predecessor     = had ? pred_rd : '0;
  assign has_predecessor = had;
  assign last            = (emit_col == used_m1);

endmodule

// ===== rtl/core/wmpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Windowed minimum-path cost controller
// Sequences accept, window scan, cost write and result emission.
// ----------------------------------------------------------------------------
`include "windowed_min_path_dp_top_assert.svh"

module wmpd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  wmpd_pkg::sts_t   sts,
  output wmpd_pkg::cmd_t   cmd
);

  wmpd_pkg::state_t state;
  wmpd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wmpd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      wmpd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.first_row ? wmpd_pkg::ST_WRITE : wmpd_pkg::ST_SCAN;
        end
      end
      wmpd_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = wmpd_pkg::ST_DRAIN;
        end
      end
      wmpd_pkg::ST_DRAIN: begin
        state_next = wmpd_pkg::ST_WRITE;
      end
      wmpd_pkg::ST_WRITE: begin
        cmd.write = 1'b1;
        if (sts.row_end && sts.end_flag) begin
          state_next = wmpd_pkg::ST_EMIT_RD;
        end else begin
          state_next = wmpd_pkg::ST_IDLE;
        end
      end
      wmpd_pkg::ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = wmpd_pkg::ST_EMIT_OUT;
      end
      wmpd_pkg::ST_EMIT_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_next = 1'b1;
          state_next    = sts.emit_last ? wmpd_pkg::ST_IDLE : wmpd_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_next = wmpd_pkg::ST_IDLE;
      end
    endcase
  end

  `WMPD_NEVER(a_no_overlap, clk, rst, in_ready && out_valid, "input taken while result pending")
  `WMPD_NEVER(a_scan_first_row, clk, rst, cmd.scan && sts.first_row, "window scan on first row")
  `WMPD_ASSERT(a_emit_after_end, clk, rst, (cmd.write && sts.row_end && sts.end_flag) |=> cmd.emit_rd, "end of matrix did not start emission")

endmodule

// ===== rtl/core/windowed_min_path_dp_top.sv =====
// ----------------------------------------------------------------------------
// Windowed minimum-path cost block, top level
// Row-major matrix entries in, per-column predecessors of the last row out.
// ----------------------------------------------------------------------------
// Usage: entries arrive on the s_ stream, one transfer per matrix entry, row by
// row, with s_tlast set on the last entry of the last row. The cfg channel
// writes used_columns (index 0) and window_radius (index 1); it is always ready.
// An entry of the first row is accepted and then written. An entry of a later row
// is accepted, scans its search window (at most 64 columns), drains and is then
// written; the window minimum is found by reading one previous-row cost per
// cycle from the cost RAM. After the end entry the block sends one result per
// used column on the m_ stream and reads the predecessor RAM once per result.
// While results are pending no entry is taken; a stalled receiver holds the
// current result and everything upstream. Reset puts the block at column 0 of
// a new matrix with used_columns 64 and window_radius 10; the RAMs need no
// clearing.
// ----------------------------------------------------------------------------
module windowed_min_path_dp_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,   // entry[15:0]
  input  logic                                s_tlast,   // end_of_matrix
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [15:0]                         m_tdata,   // column[5:0], predecessor[11:6]
  output logic                                m_tuser,   // has_predecessor
  output logic                                m_tlast,   // last
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wmpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wmpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  wmpd_pkg::cmd_t             cmd;
  wmpd_pkg::sts_t             sts;
  logic [wmpd_pkg::COL_W-1:0] column;
  logic [wmpd_pkg::COL_W-1:0] predecessor;

  assign cfg_ready = 1'b1;

  wmpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wmpd_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .entry           (s_tdata[wmpd_pkg::ENTRY_W-1:0]),
    .end_of_matrix   (s_tlast),
    .cmd             (cmd),
    .sts             (sts),
    .column          (column),
    .predecessor     (predecessor),
    .has_predecessor (m_tuser),
    .last            (m_tlast)
  );

  assign m_tdata = {4'b0000, predecessor, column};

endmodule
